>>> design/ale_pkg.sv
// Shared types, codes and sizes for the array list engine.
package ale_pkg;

    localparam int CAPACITY = 8;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;

    typedef enum logic [2:0] {
        OP_APPEND = 3'd0,
        OP_INSERT = 3'd1,
        OP_REMOVE = 3'd2,
        OP_SEARCH = 3'd3,
        OP_UPDATE = 3'd4,
        OP_CLEAR  = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_BADPOS = 2'd2,
        ST_NOKEY  = 2'd3
    } t_status;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] key;
        logic [3:0]         position;
        logic [63:0]        payload;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  found_index;
        logic [63:0] found_payload;
        logic [3:0]  count;
    } t_out_item;

    typedef struct packed {
        logic [31:0] key;
        logic [63:0] payload;
    } t_rec;

    typedef struct packed {
        logic en;
        t_idx addr;
        t_rec data;
    } t_wr;

endpackage

>>> design/array_list_engine.sv
// Top level of the array list engine: command sequencer over a record store.
// Input channel (i_in_valid / o_in_ready / i_in_item) takes one command item:
// append, insert at position, remove by key, search, update payload or clear.
// Output channel (o_out_valid / i_out_ready / o_out_item) gives exactly one
// result item per command: status, matched index, matched payload, count.
//
// One command is in work at a time; o_in_ready is high only while the
// sequencer is idle. Every pass over the list goes one entry per cycle
// through the record store's single ports, whose read data is registered.
// Append, clear, insert at the end, rejected and empty-list commands make
// no pass; search and update scan from the front up to the first hit,
// insert shifts the entries from the last down to the position, and remove
// scans, then shifts the entries behind the hit. o_in_ready rises with the
// result, and the next item is taken in the cycle after.
//
// The result waits in an output register while the next command runs; if
// the receiver still stalls when that one finishes, hold in the finish state.
// Reset (synchronous, active low) empties the list and drops a pending result;
// records are not cleared, since entries at or above the count are never read.
module array_list_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ale_pkg::t_in_item i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output ale_pkg::t_out_item o_out_item
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_EXEC = 7'b0000010,
        S_SCAN = 7'b0000100,
        S_SHUP = 7'b0001000,
        S_INSW = 7'b0010000,
        S_SHDN = 7'b0100000,
        S_FIN  = 7'b1000000
    } t_state;

    // control state
    t_state             r_state,     n_state;
    ale_pkg::t_cnt      r_cnt,       n_cnt;
    logic               r_issue,     n_issue;
    logic               r_pend,      n_pend;
    logic               r_out_valid, n_out_valid;

    // payload state
    ale_pkg::t_in_item  r_cmd,       n_cmd;
    ale_pkg::t_idx      r_ptr,       n_ptr;
    ale_pkg::t_idx      r_pend_addr, n_pend_addr;
    ale_pkg::t_idx      r_hit,       n_hit;
    ale_pkg::t_status   r_status,    n_status;
    logic [63:0]        r_fpay,      n_fpay;
    ale_pkg::t_out_item r_out,       n_out;

    ale_pkg::t_wr       w_wr;
    ale_pkg::t_idx      w_raddr;
    ale_pkg::t_rec      w_rdata;
    ale_pkg::t_idx      w_last;
    ale_pkg::t_idx      w_pos_idx;
    logic               w_full;
    logic               w_badpos;

    ale_mem u_mem (
        .i_clk   (i_clk),
        .i_wr    (w_wr),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // index of the last held entry, only meaningful while count is nonzero
    assign w_last    = ale_pkg::t_idx'(r_cnt - ale_pkg::t_cnt'(1));
    assign w_pos_idx = ale_pkg::t_idx'(r_cmd.position);
    assign w_full    = (r_cnt >= ale_pkg::t_cnt'(ale_pkg::CAPACITY));
    assign w_badpos  = (8'(r_cmd.position) > 8'(r_cnt));

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_issue     = r_issue;
        n_pend      = r_pend;
        n_out_valid = r_out_valid && !i_out_ready;
        n_cmd       = r_cmd;
        n_ptr       = r_ptr;
        n_pend_addr = r_pend_addr;
        n_hit       = r_hit;
        n_status    = r_status;
        n_fpay      = r_fpay;
        n_out       = r_out;
        w_wr        = '0;
        w_raddr     = r_ptr;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd    = i_in_item;
                    n_status = ale_pkg::ST_OK;
                    n_hit    = '0;
                    n_fpay   = '0;
                    n_state  = S_EXEC;
                end
            end

            S_EXEC: begin
                n_state = S_FIN;
                case (ale_pkg::t_op'(r_cmd.operation))
                    ale_pkg::OP_APPEND: begin
                        if (w_full) begin
                            n_status = ale_pkg::ST_FULL;
                        end else begin
                            w_wr.en   = 1'b1;
                            w_wr.addr = ale_pkg::t_idx'(r_cnt);
                            w_wr.data = {r_cmd.key, r_cmd.payload};
                            n_cnt     = r_cnt + ale_pkg::t_cnt'(1);
                        end
                    end
                    ale_pkg::OP_INSERT: begin
                        if (w_badpos) begin
                            n_status = ale_pkg::ST_BADPOS;
                        end else if (w_full) begin
                            n_status = ale_pkg::ST_FULL;
                        end else if (8'(r_cmd.position) == 8'(r_cnt)) begin
                            // insert at the end: nothing to shift
                            w_wr.en   = 1'b1;
                            w_wr.addr = w_pos_idx;
                            w_wr.data = {r_cmd.key, r_cmd.payload};
                            n_cnt     = r_cnt + ale_pkg::t_cnt'(1);
                        end else begin
                            n_ptr   = w_last;
                            n_issue = 1'b1;
                            n_pend  = 1'b0;
                            n_state = S_SHUP;
                        end
                    end
                    ale_pkg::OP_REMOVE, ale_pkg::OP_SEARCH, ale_pkg::OP_UPDATE: begin
                        if (r_cnt == '0) begin
                            n_status = ale_pkg::ST_NOKEY;
                        end else begin
                            n_ptr   = '0;
                            n_issue = 1'b1;
                            n_pend  = 1'b0;
                            n_state = S_SCAN;
                        end
                    end
                    ale_pkg::OP_CLEAR: begin
                        n_cnt = '0;
                    end
                    default: begin
                        // unused codes leave the list alone
                    end
                endcase
            end

            S_SCAN: begin
                // issue reads from the front, compare each entry in the cycle after its read
                if (r_issue) begin
                    n_pend      = 1'b1;
                    n_pend_addr = r_ptr;
                    if (r_ptr == w_last) begin
                        n_issue = 1'b0;
                    end else begin
                        n_ptr = r_ptr + ale_pkg::t_idx'(1);
                    end
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    if (w_rdata.key == r_cmd.key) begin
                        n_hit   = r_pend_addr;
                        n_issue = 1'b0;
                        n_pend  = 1'b0;
                        n_state = S_FIN;
                        case (ale_pkg::t_op'(r_cmd.operation))
                            ale_pkg::OP_SEARCH: begin
                                n_fpay = w_rdata.payload;
                            end
                            ale_pkg::OP_UPDATE: begin
                                w_wr.en   = 1'b1;
                                w_wr.addr = r_pend_addr;
                                w_wr.data = {w_rdata.key, r_cmd.payload};
                            end
                            default: begin
                                // remove: close the gap unless the hit is last
                                if (r_pend_addr == w_last) begin
                                    n_cnt = r_cnt - ale_pkg::t_cnt'(1);
                                end else begin
                                    n_ptr   = r_pend_addr + ale_pkg::t_idx'(1);
                                    n_issue = 1'b1;
                                    n_state = S_SHDN;
                                end
                            end
                        endcase
                    end else if (!r_issue) begin
                        n_status = ale_pkg::ST_NOKEY;
                        n_state  = S_FIN;
                    end
                end
            end

            S_SHUP: begin
                // move entries up one slot, from the last down to the position
                if (r_issue) begin
                    n_pend      = 1'b1;
                    n_pend_addr = r_ptr;
                    if (r_ptr == w_pos_idx) begin
                        n_issue = 1'b0;
                    end else begin
                        n_ptr = r_ptr - ale_pkg::t_idx'(1);
                    end
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    w_wr.en   = 1'b1;
                    w_wr.addr = r_pend_addr + ale_pkg::t_idx'(1);
                    w_wr.data = w_rdata;
                    if (!r_issue) begin
                        n_state = S_INSW;
                    end
                end
            end

            S_INSW: begin
                w_wr.en   = 1'b1;
                w_wr.addr = w_pos_idx;
                w_wr.data = {r_cmd.key, r_cmd.payload};
                n_cnt     = r_cnt + ale_pkg::t_cnt'(1);
                n_state   = S_FIN;
            end

            S_SHDN: begin
                // move entries down one slot, from past the hit to the last
                if (r_issue) begin
                    n_pend      = 1'b1;
                    n_pend_addr = r_ptr;
                    if (r_ptr == w_last) begin
                        n_issue = 1'b0;
                    end else begin
                        n_ptr = r_ptr + ale_pkg::t_idx'(1);
                    end
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    w_wr.en   = 1'b1;
                    w_wr.addr = r_pend_addr - ale_pkg::t_idx'(1);
                    w_wr.data = w_rdata;
                    if (!r_issue) begin
                        n_cnt   = r_cnt - ale_pkg::t_cnt'(1);
                        n_state = S_FIN;
                    end
                end
            end

            S_FIN: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out.status        = r_status;
                    n_out.found_index   = 3'(r_hit);
                    n_out.found_payload = r_fpay;
                    n_out.count         = 4'(r_cnt);
                    n_out_valid         = 1'b1;
                    n_state             = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_issue     <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_issue     <= n_issue;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_ptr       <= n_ptr;
        r_pend_addr <= n_pend_addr;
        r_hit       <= n_hit;
        r_status    <= n_status;
        r_fpay      <= n_fpay;
        r_out       <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // list never holds more than its capacity
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= ale_pkg::t_cnt'(ale_pkg::CAPACITY))
        else $error("entry count above capacity");

    // a full status is only reported with a full list
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status == ale_pkg::ST_FULL)
        |-> (o_out_item.count == 4'(ale_pkg::CAPACITY)))
        else $error("full status with list not full");

    // scan compares only held entries
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_pend) |-> (8'(r_pend_addr) < 8'(r_cnt)))
        else $error("scan read beyond held entries");

    // an accepted command always enters execution next
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_EXEC))
        else $error("accepted command not executed");

endmodule

>>> design/ale_mem.sv
// Record store: one write port, one read port with registered data.
module ale_mem (
    input  logic          i_clk,
    input  ale_pkg::t_wr  i_wr,
    input  ale_pkg::t_idx i_raddr,
    output ale_pkg::t_rec o_rdata
);

    ale_pkg::t_rec r_mem [ale_pkg::CAPACITY];
    ale_pkg::t_rec r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
